### hw/rtl/itb_pkg.sv
// itb_pkg: constants and helpers shared by the radix-text converter
// no dependencies

package itb_pkg;

    localparam int MAX_DIGITS_DEF  = 32;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int NUM_REGS        = 4;
    localparam int REG_WIDTH       = 64;
    localparam int CHARS_PER_REG   = 8;
    localparam int TOTAL_CHARS     = NUM_REGS * CHARS_PER_REG;
    localparam int IDX_WIDTH       = 2;

    localparam logic [63:0] ALPHA0_RESET = 64'h3736353433323130;
    localparam logic [63:0] ALPHA1_RESET = 64'h0000000000003938;

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_CR    = 8'h0d;

    function automatic logic is_forbidden(input logic [7:0] c);
        return c == CH_MINUS || c == CH_PLUS || c == CH_TAB || c == CH_LF ||
               c == CH_VT || c == CH_SPACE || c == CH_FF || c == CH_CR;
    endfunction

endpackage

### hw/rtl/itb_divider.sv
// itb_divider: restoring bit-serial divider, one quotient bit per cycle
// depends on itb_pkg

module itb_divider
    import itb_pkg::*;
#(
    parameter int VW = VALUE_WIDTH_DEF,
    parameter int RW = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [VW-1:0] dividend,
    input  logic [RW-1:0] divisor,
    output logic          done,
    output logic [VW-1:0] quotient,
    output logic [RW-1:0] remainder
);

    localparam int CW = $clog2(VW + 1);

    logic [VW-1:0] q_reg;
    logic [RW:0]   r_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [RW:0]   shifted;
    logic [RW:0]   diff;

    assign shifted = {r_reg[RW-1:0], q_reg[VW-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(VW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (run_reg)
        begin
            if (!diff[RW])
            begin
                r_reg <= diff;
                q_reg <= {q_reg[VW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                q_reg <= {q_reg[VW-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[RW-1:0];

endmodule

### hw/rtl/integer_to_base_digits_core.sv
// integer_to_base_digits_core: signed value to text in a configured radix
// depends on itb_pkg and itb_divider
// sequence: alphabet length scan, pairwise alphabet check, then one division per digit
// one value at a time: start is taken only while idle; each digit uses the bit-serial divider
// emits an optional minus sign, then one word per cycle from the digit stack; busy until the last word
// reset: alphabet returns to "0123456789", control goes idle

module integer_to_base_digits_core
    import itb_pkg::*;
#(
    parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                   cfg_we,
    input  logic [IDX_WIDTH-1:0]   cfg_index,
    input  logic [REG_WIDTH-1:0]   cfg_data,
    output logic                   strobe,
    output logic [7:0]             character,
    output logic                   last,
    output logic                   base_bad
);

    localparam int LIMIT = (MAX_DIGITS < TOTAL_CHARS) ? MAX_DIGITS : TOTAL_CHARS;
    localparam int AW    = $clog2(TOTAL_CHARS);
    localparam int LW    = $clog2(LIMIT + 1);
    localparam int RW    = LW;
    localparam int SD    = VALUE_WIDTH;
    localparam int SW    = $clog2(SD + 1);
    localparam int DW    = $clog2(SD);

    typedef enum logic [2:0] {
        S_IDLE, S_LEN, S_CHK, S_DIV, S_WAIT, S_SIGN, S_OUT
    } state_t;

    logic [REG_WIDTH-1:0]   alpha_reg [NUM_REGS];
    state_t                 state_reg;
    logic [LW-1:0]          len_reg;
    logic [AW-1:0]          a_reg;
    logic [LW-1:0]          b_reg;
    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [RW-1:0]          dig_reg [SD];
    logic [SW-1:0]          nd_reg;
    logic                   strobe_reg;
    logic [7:0]             char_reg;
    logic                   last_reg;
    logic                   bad_reg;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_q;
    logic [RW-1:0]          div_r;

    function automatic logic [7:0] pick(input logic [AW-1:0] k,
                                        input logic [REG_WIDTH-1:0] r0,
                                        input logic [REG_WIDTH-1:0] r1,
                                        input logic [REG_WIDTH-1:0] r2,
                                        input logic [REG_WIDTH-1:0] r3);
        logic [REG_WIDTH-1:0] w;
        unique case (k[AW-1:AW-2])
            2'd0: w = r0;
            2'd1: w = r1;
            2'd2: w = r2;
            default: w = r3;
        endcase
        return w[k[2:0]*8 +: 8];
    endfunction

    logic [7:0] ch_a;
    logic [7:0] ch_b;
    logic [7:0] ch_d;
    logic [RW-1:0] top_dig;

    assign top_dig = dig_reg[DW'(nd_reg - 1'b1)];
    assign ch_a = pick(a_reg, alpha_reg[0], alpha_reg[1], alpha_reg[2], alpha_reg[3]);
    assign ch_b = pick(AW'(b_reg), alpha_reg[0], alpha_reg[1], alpha_reg[2],
                       alpha_reg[3]);
    assign ch_d = pick(AW'(top_dig), alpha_reg[0], alpha_reg[1], alpha_reg[2],
                       alpha_reg[3]);

    assign div_start = (state_reg == S_DIV);

    itb_divider #(.VW(VALUE_WIDTH), .RW(RW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (len_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg[0] <= ALPHA0_RESET;
            alpha_reg[1] <= ALPHA1_RESET;
            alpha_reg[2] <= '0;
            alpha_reg[3] <= '0;
        end
        else if (cfg_we)
        begin
            alpha_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WAIT && div_done)
            dig_reg[nd_reg[DW-1:0]] <= div_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            neg_reg    <= 1'b0;
            mag_reg    <= '0;
            nd_reg     <= '0;
            strobe_reg <= 1'b0;
            char_reg   <= '0;
            last_reg   <= 1'b0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg   <= value[VALUE_WIDTH-1];
                        mag_reg   <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
                        len_reg   <= '0;
                        a_reg     <= '0;
                        nd_reg    <= '0;
                        state_reg <= S_LEN;
                    end
                end
                S_LEN:
                begin
                    // count characters up to the zero byte or LIMIT
                    if (len_reg == LW'(LIMIT) || ch_a == 8'd0)
                    begin
                        if (len_reg < LW'(2))
                        begin
                            strobe_reg <= 1'b1;
                            char_reg   <= '0;
                            last_reg   <= 1'b1;
                            bad_reg    <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            a_reg     <= '0;
                            b_reg     <= LW'(1);
                            state_reg <= S_CHK;
                        end
                    end
                    else
                    begin
                        len_reg <= len_reg + 1'b1;
                        a_reg   <= a_reg + 1'b1;
                    end
                end
                S_CHK:
                begin
                    // one pair compared per cycle
                    if (is_forbidden(ch_a) || (b_reg < len_reg && ch_a == ch_b))
                    begin
                        strobe_reg <= 1'b1;
                        char_reg   <= '0;
                        last_reg   <= 1'b1;
                        bad_reg    <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else if (b_reg + 1'b1 < len_reg)
                    begin
                        b_reg <= b_reg + 1'b1;
                    end
                    else if (LW'(a_reg) + 1'b1 < len_reg)
                    begin
                        a_reg <= a_reg + 1'b1;
                        b_reg <= LW'(a_reg) + LW'(2);
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        nd_reg  <= nd_reg + 1'b1;
                        mag_reg <= div_q;
                        if (div_q == '0)
                            state_reg <= neg_reg ? S_SIGN : S_OUT;
                        else
                            state_reg <= S_DIV;
                    end
                end
                S_SIGN:
                begin
                    strobe_reg <= 1'b1;
                    char_reg   <= CH_MINUS;
                    last_reg   <= 1'b0;
                    bad_reg    <= 1'b0;
                    state_reg  <= S_OUT;
                end
                S_OUT:
                begin
                    strobe_reg <= 1'b1;
                    char_reg   <= ch_d;
                    last_reg   <= (nd_reg == SW'(1));
                    bad_reg    <= 1'b0;
                    nd_reg     <= nd_reg - 1'b1;
                    if (nd_reg == SW'(1))
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign base_bad  = bad_reg;

    a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && base_bad |-> last && character == 8'd0)
        else $error("error word must be single and zero");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("word after last");

    a_out_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> nd_reg != '0)
        else $error("digit stack empty while emitting");

endmodule
